// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define HSD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsd assertion failed");

// Implication into the next cycle, off during reset.
`define HSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsd assertion failed");

// Implication into the next cycle, live during reset as well.
`define HSD_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsd assertion failed");

`endif

// File: hw/rtl/hsd_pkg.sv
// Types and constants of the Huffman stream decoder.
package hsd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
    logic       last;
  } out_item_t;

  // Stream phases
  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_TREE    = 2'd1,
    PH_WALK    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_SEED,
    ST_BIT,
    ST_LAND,
    ST_EOF,
    ST_EOF_END,
    ST_FLUSH
  } state_t;

  localparam logic [7:0] TREE_INNER = 8'h4E;
  localparam logic [7:0] TREE_LEAF  = 8'h4C;
  localparam logic [7:0] DIGIT_0    = 8'h30;
  localparam logic [7:0] DIGIT_9    = 8'h39;

endpackage

// File: hw/rtl/hsd_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface hsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/huffman_stream_decoder_unit.sv
// Huffman stream decoder: takes one file byte per beat on bytes and gives decoded symbols,
// an end marker or one error marker on results; the last result of each byte carries last.
// The block works on one byte at a time. A count or tree byte goes from acceptance
// through execute, then pop or seed where needed, end of file and flush back to ready.
// In a payload byte each counted bit, unless the tree is a lone leaf, does one registered
// read of the node table at the child address and then checks that node. End of file can
// add a state for an extra result. Results leave through an output register and a one-deep hold
// stage, which lets the last result of a byte be marked; the sequencer stalls only while
// the output register is full and not taken. Node table and parent stack are memories
// written during the tree and need no clearing after reset.
module huffman_stream_decoder_unit #(
  parameter int MAX_NODES   = 511,
  parameter int STACK_DEPTH = 256,
  parameter int COUNT_BITS  = 32
) (
  input logic         clk,
  input logic         rst,
  hsd_stream_if.sink   bytes,
  hsd_stream_if.source results
);
  import hsd_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  // Control registers
  state_t                state, state_next;
  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] bits_left, bits_left_next;
  logic [NCW-1:0]        next_free, next_free_next;
  logic [SCW-1:0]        stack_top, stack_top_next;
  logic                  expect_leaf, expect_leaf_next;
  logic                  out_valid, out_valid_next;
  logic                  pend_valid, pend_valid_next;

  // Payload registers
  logic [7:0]  byte_q, byte_q_next;
  logic        eof_q, eof_q_next;
  logic [3:0]  bit_cnt, bit_cnt_next;
  logic [NW-1:0] top_node, top_node_next;
  logic        top_filled, top_filled_next;
  logic        root_leaf, root_leaf_next;
  logic [7:0]  root_sym, root_sym_next;
  logic [NW-1:0] root_left, root_left_next;
  logic [NW-1:0] root_right, root_right_next;
  logic        cur_leaf, cur_leaf_next;
  logic [7:0]  cur_sym, cur_sym_next;
  logic [NW-1:0] cur_left, cur_left_next;
  logic [NW-1:0] cur_right, cur_right_next;
  logic        walk_zero, walk_zero_next;
  kind_t       pend_kind, pend_kind_next;
  logic [7:0]  pend_sym, pend_sym_next;
  out_item_t   out_item, out_item_next;

  // Memories and their ports
  logic [8:0]    info_mem  [MAX_NODES];
  logic [NW-1:0] left_mem  [MAX_NODES];
  logic [NW-1:0] right_mem [MAX_NODES];
  logic [NW:0]   stk_mem   [STACK_DEPTH];

  logic          info_we, left_we, right_we, node_re, stk_we, stk_re;
  logic [NW-1:0] info_wa, link_wa, node_ra;
  logic [8:0]    info_wd;
  logic [NW-1:0] link_wd;
  logic [SW-1:0] stk_wa, stk_ra;
  logic [NW:0]   stk_wd;
  logic [8:0]    rd_info;
  logic [NW-1:0] rd_left, rd_right;
  logic [NW:0]   stk_rd;

  // Emit requests
  logic        emit_go, flush_go;
  kind_t       emit_kind;
  logic [7:0]  emit_sym;
  logic        out_free;

  in_item_t in_beat;

  assign in_beat        = bytes.payload;
  assign bytes.ready    = (state == ST_IDLE);
  assign results.valid  = out_valid;
  assign results.payload = out_item;
  assign out_free       = !out_valid || results.ready;

  // Sequencer: next state, stream state and memory controls
  always_comb begin
    logic                  is_digit;
    logic [3:0]            digit;
    logic [COUNT_BITS+3:0] count_prod;
    logic                  tree_fail;
    logic                  place;
    logic                  place_leaf;
    logic [NW-1:0]         new_idx;
    logic                  attached;
    logic                  popped;
    logic [SCW-1:0]        st_after;
    logic                  bit_val;
    logic [NW-1:0]         child;
    logic                  clear;

    state_next       = state;
    phase_next       = phase;
    bits_left_next   = bits_left;
    next_free_next   = next_free;
    stack_top_next   = stack_top;
    expect_leaf_next = expect_leaf;
    byte_q_next      = byte_q;
    eof_q_next       = eof_q;
    bit_cnt_next     = bit_cnt;
    top_node_next    = top_node;
    top_filled_next  = top_filled;
    root_leaf_next   = root_leaf;
    root_sym_next    = root_sym;
    root_left_next   = root_left;
    root_right_next  = root_right;
    cur_leaf_next    = cur_leaf;
    cur_sym_next     = cur_sym;
    cur_left_next    = cur_left;
    cur_right_next   = cur_right;
    walk_zero_next   = walk_zero;

    info_we  = 1'b0;
    left_we  = 1'b0;
    right_we = 1'b0;
    node_re  = 1'b0;
    stk_we   = 1'b0;
    stk_re   = 1'b0;
    info_wa  = next_free[NW-1:0];
    info_wd  = 9'd0;
    link_wa  = top_node;
    link_wd  = next_free[NW-1:0];
    node_ra  = cur_left;
    stk_wa   = SW'(stack_top - SCW'(1));
    stk_wd   = {top_node, 1'b1};
    stk_ra   = SW'(stack_top - SCW'(2));

    emit_go   = 1'b0;
    flush_go  = 1'b0;
    emit_kind = KIND_SYMBOL;
    emit_sym  = 8'd0;

    is_digit   = (byte_q >= DIGIT_0) && (byte_q <= DIGIT_9);
    digit      = 4'(byte_q - DIGIT_0);
    count_prod = ({4'd0, bits_left} << 3) + ({4'd0, bits_left} << 1)
               + {{COUNT_BITS{1'b0}}, digit};
    tree_fail  = 1'b0;
    place      = 1'b0;
    place_leaf = 1'b0;
    new_idx    = next_free[NW-1:0];
    attached   = 1'b0;
    popped     = 1'b0;
    st_after   = stack_top;
    bit_val    = byte_q[7];
    child      = cur_left;
    clear      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        // Take the next beat
        if (bytes.valid) begin
          byte_q_next = in_beat.data_byte;
          eof_q_next  = in_beat.end_of_file;
          state_next  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_EOF;
          if (phase == PH_COUNT && is_digit) begin
            // Fold one decimal digit into the count
            if (count_prod[COUNT_BITS+3:COUNT_BITS] != 4'd0) begin
              emit_go    = 1'b1;
              emit_kind  = KIND_ERROR;
              phase_next = PH_DISCARD;
            end else begin
              bits_left_next = count_prod[COUNT_BITS-1:0];
            end
          end else if (phase == PH_COUNT || phase == PH_TREE) begin
            // Tree byte: an L marks the next byte as a leaf; else place a node and link it under the open parent
            phase_next = PH_TREE;
            if (expect_leaf) begin
              if (next_free >= NCW'(MAX_NODES)) begin
                tree_fail = 1'b1;
              end else begin
                place      = 1'b1;
                place_leaf = 1'b1;
              end
            end else if (byte_q == TREE_INNER) begin
              if (next_free >= NCW'(MAX_NODES) || stack_top >= SCW'(STACK_DEPTH)) begin
                tree_fail = 1'b1;
              end else begin
                place = 1'b1;
              end
            end else if (byte_q == TREE_LEAF) begin
              expect_leaf_next = 1'b1;
            end else begin
              tree_fail = 1'b1;
            end

            if (tree_fail) begin
              emit_go    = 1'b1;
              emit_kind  = KIND_ERROR;
              phase_next = PH_DISCARD;
            end else if (place) begin
              info_we          = 1'b1;
              info_wd          = place_leaf ? {1'b1, byte_q} : 9'd0;
              next_free_next   = next_free + NCW'(1);
              expect_leaf_next = 1'b0;
              if (next_free == '0) begin
                root_leaf_next = place_leaf;
                root_sym_next  = byte_q;
              end
              // Link into the parent on top of the stack
              if (next_free != '0 && stack_top != '0) begin
                attached = 1'b1;
                if (!top_filled) begin
                  left_we         = 1'b1;
                  top_filled_next = 1'b1;
                  if (top_node == '0) root_left_next = new_idx;
                end else begin
                  right_we = 1'b1;
                  popped   = 1'b1;
                  if (top_node == '0) root_right_next = new_idx;
                end
              end
              st_after = stack_top - SCW'(popped);
              if (!place_leaf) begin
                // Push the new inner node; a filled parent below moves to memory
                if (attached && !popped) stk_we = 1'b1;
                top_node_next   = new_idx;
                top_filled_next = 1'b0;
                stack_top_next  = st_after + SCW'(1);
              end else begin
                stack_top_next = st_after;
                if (popped && st_after != '0) begin
                  stk_re     = 1'b1;
                  state_next = ST_POP;
                end else if (st_after == '0) begin
                  // Tree complete
                  phase_next = PH_WALK;
                  state_next = ST_SEED;
                end
              end
            end
          end else if (phase == PH_WALK) begin
            bit_cnt_next = 4'd8;
            state_next   = ST_BIT;
          end
        end
      end

      ST_POP: begin
        // Restore the parent under the popped one
        top_node_next   = stk_rd[NW:1];
        top_filled_next = stk_rd[0];
        state_next      = ST_EOF;
      end

      ST_SEED: begin
        // Start the walk at the root
        cur_leaf_next  = root_leaf;
        cur_sym_next   = root_sym;
        cur_left_next  = root_left;
        cur_right_next = root_right;
        walk_zero_next = 1'b1;
        state_next     = ST_EOF;
      end

      ST_BIT: begin
        if (bits_left == '0 || bit_cnt == 4'd0) begin
          state_next = ST_EOF;
        end else begin
          // Shift out one payload bit and step one edge
          bits_left_next = bits_left - COUNT_BITS'(1);
          bit_cnt_next   = bit_cnt - 4'd1;
          byte_q_next    = {byte_q[6:0], 1'b0};
          if (cur_leaf && root_leaf) begin
            walk_zero_next = 1'b1;
          end else begin
            if (cur_leaf) child = bit_val ? root_right : root_left;
            else          child = bit_val ? cur_right : cur_left;
            node_re        = 1'b1;
            node_ra        = child;
            walk_zero_next = (child == '0);
            state_next     = ST_LAND;
          end
        end
      end

      ST_LAND: begin
        // Latch the reached node; a leaf gives its symbol
        if (out_free) begin
          cur_leaf_next  = rd_info[8];
          cur_sym_next   = rd_info[7:0];
          cur_left_next  = rd_left;
          cur_right_next = rd_right;
          if (rd_info[8]) begin
            emit_go   = 1'b1;
            emit_kind = KIND_SYMBOL;
            emit_sym  = rd_info[7:0];
          end
          state_next = ST_BIT;
        end
      end

      ST_EOF: begin
        if (out_free) begin
          state_next = ST_FLUSH;
          if (eof_q) begin
            case (phase)
              PH_COUNT, PH_TREE: begin
                emit_go   = 1'b1;
                emit_kind = KIND_ERROR;
                clear     = 1'b1;
              end
              PH_WALK: begin
                if (bits_left != '0 || !cur_leaf) begin
                  emit_go   = 1'b1;
                  emit_kind = KIND_ERROR;
                  clear     = 1'b1;
                end else if (walk_zero) begin
                  // Lone leaf: its symbol once, then the end
                  emit_go    = 1'b1;
                  emit_kind  = KIND_SYMBOL;
                  emit_sym   = cur_sym;
                  state_next = ST_EOF_END;
                end else begin
                  emit_go   = 1'b1;
                  emit_kind = KIND_END;
                  clear     = 1'b1;
                end
              end
              default: clear = 1'b1;
            endcase
          end
        end
      end

      ST_EOF_END: begin
        if (out_free) begin
          emit_go    = 1'b1;
          emit_kind  = KIND_END;
          clear      = 1'b1;
          state_next = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // Release the held result as the last one of this beat
        if (out_free) begin
          flush_go   = pend_valid;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // Return to the start of a new file
    if (clear) begin
      phase_next       = PH_COUNT;
      bits_left_next   = '0;
      next_free_next   = '0;
      stack_top_next   = '0;
      expect_leaf_next = 1'b0;
      walk_zero_next   = 1'b1;
    end

    if (state == ST_EXEC) begin
      stk_wa  = SW'(stack_top - SCW'(1));
      link_wa = top_node;
      link_wd = new_idx;
      stk_ra  = SW'(st_after - SCW'(1));
    end
  end

  // Result hold stage and output register
  always_comb begin
    out_valid_next  = out_valid && !results.ready;
    out_item_next   = out_item;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_sym_next   = pend_sym;
    if ((emit_go || flush_go) && pend_valid) begin
      out_valid_next       = 1'b1;
      out_item_next.kind   = pend_kind;
      out_item_next.symbol = pend_sym;
      out_item_next.last   = flush_go;
    end
    if (emit_go) begin
      pend_valid_next = 1'b1;
      pend_kind_next  = emit_kind;
      pend_sym_next   = emit_sym;
    end else if (flush_go) begin
      pend_valid_next = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_COUNT;
      bits_left   <= '0;
      next_free   <= '0;
      stack_top   <= '0;
      expect_leaf <= 1'b0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      bits_left   <= bits_left_next;
      next_free   <= next_free_next;
      stack_top   <= stack_top_next;
      expect_leaf <= expect_leaf_next;
      out_valid   <= out_valid_next;
      pend_valid  <= pend_valid_next;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    byte_q     <= byte_q_next;
    eof_q      <= eof_q_next;
    bit_cnt    <= bit_cnt_next;
    top_node   <= top_node_next;
    top_filled <= top_filled_next;
    root_leaf  <= root_leaf_next;
    root_sym   <= root_sym_next;
    root_left  <= root_left_next;
    root_right <= root_right_next;
    cur_leaf   <= cur_leaf_next;
    cur_sym    <= cur_sym_next;
    cur_left   <= cur_left_next;
    cur_right  <= cur_right_next;
    walk_zero  <= walk_zero_next;
    pend_kind  <= pend_kind_next;
    pend_sym   <= pend_sym_next;
    out_item   <= out_item_next;
  end

  // Node table: leaf flag and symbol, left child, right child
  always_ff @(posedge clk) begin
    if (info_we)  info_mem[info_wa]  <= info_wd;
    if (left_we)  left_mem[link_wa]  <= link_wd;
    if (right_we) right_mem[link_wa] <= link_wd;
    if (node_re) begin
      rd_info  <= info_mem[node_ra];
      rd_left  <= left_mem[node_ra];
      rd_right <= right_mem[node_ra];
    end
  end

  // Parent stack below the top entry
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

endmodule

// File: hw/rtl/hsd_checker.sv
// Port-level checks of the Huffman stream decoder, bound to its top level.
`include "assert_macros.svh"

module hsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_symbol,
  input logic       out_last
);
  import hsd_pkg::*;

  // No result right after reset
  `HSD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

  // A stalled result holds
  `HSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_symbol) && $stable(out_last))

  // Only decoded symbols carry a byte
  `HSD_ASSERT_IMP(a_sym_zero, clk, rst, out_valid && out_kind != KIND_SYMBOL, out_symbol == 8'd0)

  // The end marker closes its beat
  `HSD_ASSERT_IMP(a_end_last, clk, rst, out_valid && out_kind == KIND_END, out_last)

  // A taken beat is worked on before the next one
  `HSD_ASSERT_NEXT(a_one_beat, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind huffman_stream_decoder_unit hsd_checker u_hsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_kind  (results.payload.kind),
  .out_symbol(results.payload.symbol),
  .out_last  (results.payload.last)
);
